[sv/sgr_pkg.sv]
package sgr_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned CFG_W   = 7;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               is_final;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] out_value;
    logic               run_last;
  } out_item_t;

endpackage

[sv/sgr_buf.sv]
module sgr_buf #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/stream_group_reverse_top.sv]
// Channel | Direction | Handshake        | Payload
// in_     | input     | in_valid/stall   | in_item_t  (value, is_final)
// out_    | output    | out_valid/stall  | out_item_t (out_value, run_last)
// cfg_    | input     | cfg_valid/ready  | cfg_data   (group size)
//
// Each input transfer writes one buffer entry. A transfer that completes a
// group or ends the list starts a drain of n results, one per cycle while
// the output is not stalled, limited by the single read port of the group
// buffer; the input stalls until the last read is issued.
// Reset clears the fill count, the drain count and sets group size to 1; the
// buffer itself is not cleared. A stalled output holds its value and pauses
// the drain.
module stream_group_reverse_top
  import sgr_pkg::*;
#(
  parameter int unsigned MAX_GROUP  = 64,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  // stored width: the smaller of VALUE_BITS and FIELD_W; value bits above it never show
  localparam int unsigned SB = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
  localparam int unsigned IW = $clog2(MAX_GROUP);
  localparam int unsigned CW = $clog2(MAX_GROUP + 1);
  localparam logic [CFG_W-1:0] MAX_SIZE = CFG_W'(MAX_GROUP);

  logic [CFG_W-1:0] size_r;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic [IW-1:0]    addr_r, addr_nxt;
  logic             rev_r, rev_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_r, last_nxt;

  logic [CFG_W-1:0] eff_size;
  logic [CW-1:0]    n_cnt;
  logic             in_xfer;
  logic             full_grp;
  logic             emit;
  logic             rd_en;
  logic [SB-1:0]    rd_data;

  // clamp the programmed size into 1..MAX_GROUP
  always_comb begin
    if (size_r == '0) begin
      eff_size = CFG_W'(1);
    end else if (size_r > MAX_SIZE) begin
      eff_size = MAX_SIZE;
    end else begin
      eff_size = size_r;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      size_r <= cfg_data;
    end
  end

  // accept only once every read of the previous run has been issued
  assign in_stall = (rem_r != '0);
  assign in_xfer  = in_valid && !in_stall;
  assign n_cnt    = fill_r + CW'(1);
  assign full_grp = (CFG_W'(n_cnt) >= eff_size);
  assign emit     = full_grp || in_item.is_final;

  // read into the output register when it is empty or being drained
  assign rd_en = (rem_r != '0) && (!out_valid_r || !out_stall);

  always_comb begin
    fill_nxt      = fill_r;
    rem_nxt       = rem_r;
    addr_nxt      = addr_r;
    rev_nxt       = rev_r;
    out_valid_nxt = out_valid_r;
    last_nxt      = last_r;

    if (rd_en) begin
      rem_nxt       = rem_r - CW'(1);
      addr_nxt      = rev_r ? addr_r - IW'(1) : addr_r + IW'(1);
      out_valid_nxt = 1'b1;
      last_nxt      = (rem_r == CW'(1));
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (in_xfer) begin
      if (emit) begin
        // full group: newest first; short tail: oldest first
        fill_nxt = '0;
        rem_nxt  = n_cnt;
        rev_nxt  = full_grp;
        addr_nxt = full_grp ? fill_r[IW-1:0] : '0;
      end else begin
        fill_nxt = n_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    rev_r  <= rev_nxt;
    last_r <= last_nxt;
  end

  sgr_buf #(
    .DEPTH  (MAX_GROUP),
    .DATA_W (SB)
  ) u_buf (
    .clk     (clk),
    .wr_en   (in_xfer),
    .wr_addr (fill_r[IW-1:0]),
    .wr_data (in_item.value[SB-1:0]),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign out_valid          = out_valid_r;
  assign out_item.out_value = FIELD_W'(rd_data);
  assign out_item.run_last  = last_r;

endmodule

[tb/sv/stream_group_reverse_checker.sv]
`timescale 1ns / 1ps

module stream_group_reverse_checker
  import sgr_pkg::*;
#(
  parameter int unsigned MAX_GROUP = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_item_t         in_item,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_item_t        out_item,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output int unsigned      outstanding,
  output int unsigned      mismatches
);

  logic [CFG_W-1:0]   group_size;
  logic [FIELD_W-1:0] held [MAX_GROUP];
  int unsigned        fill;
  int unsigned        err_cnt;
  out_item_t          reordered_q [$];

  function automatic int unsigned active_size(logic [CFG_W-1:0] gs);
    if (gs == 0) return 1;
    if (gs > MAX_GROUP) return MAX_GROUP;
    return 32'(gs);
  endfunction

  // Buffer one value; on a full group emit newest first, on list end in order.
  task automatic take_value(in_item_t item);
    int unsigned n;
    bit          full;
    out_item_t   r;
    if (fill >= MAX_GROUP) fill = 0;
    held[fill] = item.value;
    fill++;
    n    = fill;
    full = (n >= active_size(group_size));
    if (full || item.is_final) begin
      for (int unsigned k = 0; k < n; k++) begin
        r.out_value = full ? held[n-1-k] : held[k];
        r.run_last  = (k == n - 1);
        reordered_q.push_back(r);
      end
      fill = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      group_size = CFG_W'(1);
      fill       = 0;
      reordered_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) group_size = cfg_data;
      if (in_valid && !in_stall) take_value(in_item);
      if (out_valid && !out_stall) begin
        if (reordered_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: expected none, got value %h last %b",
                   $time, out_item.out_value, out_item.run_last);
        end else begin
          want = reordered_q.pop_front();
          if (out_item.out_value !== want.out_value) begin
            err_cnt++;
            $display("%0t: out_value mismatch: expected %h, got %h",
                     $time, want.out_value, out_item.out_value);
          end
          if (out_item.run_last !== want.run_last) begin
            err_cnt++;
            $display("%0t: run_last mismatch: expected %b, got %b",
                     $time, want.run_last, out_item.run_last);
          end
        end
      end
    end
    outstanding <= reordered_q.size();
    mismatches  <= err_cnt;
  end

endmodule

[tb/sv/stream_group_reverse_top_tb.sv]
`timescale 1ns / 1ps

module stream_group_reverse_top_tb;
  import sgr_pkg::*;

  localparam int unsigned MAX_GROUP    = 64;
  localparam int unsigned RANDOM_ITEMS = 140;
  // wait for a full drained group plus margin
  localparam int unsigned DRAIN_CYCLES = MAX_GROUP + 6;
  // an item that causes no result is done in the cycle after its transfer
  localparam int unsigned QUIET_CYCLES = 4;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  int unsigned outstanding;
  int unsigned mismatches;
  // suppress random idling on both sides during one long stretch
  bit          calm = 1'b0;

  always #6 clk = ~clk;

  stream_group_reverse_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  stream_group_reverse_checker #(.MAX_GROUP(MAX_GROUP)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // Receiver: stall with a chance of about 23 percent, never while calm.
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 23);
  end

  // Hold the input idle until every predicted result has arrived, then let
  // the block finish any trailing work.
  task automatic settle(int unsigned extra);
    in_valid <= 1'b0;
    // step once so the checker's count reflects the last transfer
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Offer one value; unless calm, insert random gaps first, then hold it until the transfer.
  task automatic send_value(logic [FIELD_W-1:0] v, logic fin);
    if (!calm) begin
      while ($urandom_range(0, 99) < 23) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item  <= '{value: v, is_final: fin};
    do @(posedge clk); while (in_stall);
  endtask

  // Write the group size only once the block has gone quiet.
  task automatic write_group_size(logic [CFG_W-1:0] gs);
    settle(QUIET_CYCLES);
    cfg_valid <= 1'b1;
    cfg_data  <= gs;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned      sent;
    int unsigned      span;
    int unsigned      lists;
    int unsigned      len;
    int unsigned      pick;
    bit               first;
    bit               unfinished;
    logic             fin;
    logic [CFG_W-1:0] gs;

    sent  = 0;
    first = 1'b1;

    // synchronous reset, held before the first stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset group size of one: every value passes straight through
    send_value(16'h0000, 1'b0);
    send_value(16'hFFFF, 1'b1);

    // group size zero behaves as one
    write_group_size('0);
    send_value(16'h1234, 1'b0);
    send_value(16'h5555, 1'b1);

    // full group reversed, short tail in order, final element closing a group
    write_group_size(7'd3);
    send_value(16'hAAAA, 1'b0);
    send_value(16'h0001, 1'b0);
    send_value(16'h8000, 1'b0);
    send_value(16'h0002, 1'b0);
    send_value(16'h0003, 1'b1);
    send_value(16'h0004, 1'b0);
    send_value(16'h0005, 1'b0);
    send_value(16'h0006, 1'b1);

    // lower the size mid-group: the next append flushes all four reversed
    write_group_size(7'd5);
    send_value(16'h0010, 1'b0);
    send_value(16'h0011, 1'b0);
    send_value(16'h0012, 1'b0);
    write_group_size(7'd2);
    send_value(16'h0013, 1'b0);

    // all-ones size saturates to the largest group; a short list ends in order
    write_group_size(7'h7F);
    send_value(16'h7FFF, 1'b0);
    send_value(16'hC3C3, 1'b0);
    send_value(16'h3C3C, 1'b1);

    // Random phases: pick a size, then run well-formed lists with random
    // content, mixed with early ends and lists left open across the write.
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (first)          gs = 7'(MAX_GROUP);
      else if (pick == 0) gs = '0;
      else if (pick == 9) gs = 7'($urandom_range(MAX_GROUP + 1, 127));
      else                gs = 7'($urandom_range(1, 8));
      write_group_size(gs);
      span  = (gs == 0) ? 1 : (gs > MAX_GROUP) ? MAX_GROUP : gs;
      lists = (span >= 32) ? 1 : $urandom_range(1, 4);
      for (int l = 0; l < lists; l++) begin
        if (first)           len = $urandom_range(span, span + 6);
        else if (span >= 32) len = $urandom_range(4, span + 6);
        else                 len = $urandom_range(1, 3 * span);
        unfinished = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
          calm <= (sent >= 90 && sent < 140);
          fin = (i == len - 1) ? !unfinished : ($urandom_range(0, 99) < 6);
          send_value(16'($urandom_range(0, 16'hFFFF)), fin);
          sent++;
        end
      end
      first = 1'b0;
    end

    calm <= 1'b0;
    settle(DRAIN_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("stream_group_reverse_top_tb: clean");
    end else begin
      $display("stream_group_reverse_top_tb: errors");
    end
    $finish;
  end

  // Abort a hung run well past the slowest legal finish.
  initial begin
    #5_000_000;
    $display("stream_group_reverse_top_tb: errors");
    $finish;
  end

endmodule
